>>> sv/wsjq_pkg.sv
`default_nettype none
package wsjq_pkg;

	localparam int MaxWorkersDef = 8;
	localparam int RingDepthDef = 512;
	localparam logic [63:0] Golden = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] SeedMix = 64'hD1B54A32D192ED03;
	localparam logic [3:0] WorkerCountRst = 4'd8;
	localparam logic [8:0] InlineMarginRst = 9'd30;
	localparam logic [63:0] RngSeedRst = 64'd1;

	localparam logic [1:0] RegWorkerCount = 2'd0;
	localparam logic [1:0] RegInlineMargin = 2'd1;
	localparam logic [1:0] RegRngSeed = 2'd2;

	localparam logic [2:0] StQueued = 3'd0;
	localparam logic [2:0] StInline = 3'd1;
	localparam logic [2:0] StLocal = 3'd2;
	localparam logic [2:0] StStolen = 3'd3;
	localparam logic [2:0] StNone = 3'd4;

	typedef struct packed {
		logic mode;
		logic [2:0] worker;
		logic [31:0] job;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [31:0] job_out;
		logic [2:0] victim;
		logic [12:0] pending_total;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_MOD,
		S_CHECK,
		S_READ,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

>>> sv/work_stealing_job_queues.sv
// Work-stealing job queues. Each worker owns a ring of RING_DEPTH 32-bit job handles in one
// shared memory. An enqueue request pushes a handle, or returns "run inline" when the ring is
// within inline_margin of full; a grab request pops the caller's oldest job, or on a miss draws
// one xoroshiro128+ step, reduces it modulo worker_count by restoring subtraction (one bit a
// cycle) and pops from that victim if it is active and holds a job. An enqueue passes through
// DECIDE and DONE, a local grab through DECIDE, READ and DONE, and a steal through DECIDE,
// MOD, CHECK, READ if it pops a job, and DONE; the ring read is registered.
// One request is in work at a time; the next request can be accepted as soon as the result
// appears, and only when the waiting result leaves in that cycle or has already left. Writing
// rng_seed reloads all generators at once.
`default_nettype none
module work_stealing_job_queues (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready,
	input wire logic in_valid,
	output logic in_ready,
	input wire wsjq_pkg::req_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output wsjq_pkg::rsp_t out_data
);
	localparam int MAX_WORKERS = wsjq_pkg::MaxWorkersDef;
	localparam int RING_DEPTH = wsjq_pkg::RingDepthDef;
	localparam int WW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int PW = $clog2(RING_DEPTH);
	localparam int CW = PW + 1;
	localparam int AW = WW + PW;

	wsjq_pkg::state_t state_q, state_d;

	logic [3:0] wcount_q;
	logic [8:0] margin_q;
	logic [63:0] seed_q;

	logic [PW-1:0] head_q [MAX_WORKERS];
	logic [PW-1:0] tail_q [MAX_WORKERS];
	logic [CW-1:0] cnt_q [MAX_WORKERS];
	logic [63:0] rs0_q [MAX_WORKERS];
	logic [63:0] rs1_q [MAX_WORKERS];
	logic [MAX_WORKERS-1:0] act_q;
	logic [12:0] pend_q;
	logic [31:0] ring_q [MAX_WORKERS*RING_DEPTH];
	logic [31:0] rdata_q;

	wsjq_pkg::req_t req_q;
	logic [WW-1:0] wid_q;
	logic [WW-1:0] tgt_q;
	logic [63:0] rnd_q;
	logic [3:0] rem_q;
	logic [6:0] bit_q;
	logic [3:0] wc_q;
	logic ovalid_q;
	wsjq_pkg::rsp_t odata_q;
	logic rd_used_q;
	logic [AW-1:0] raddr;

	logic wr_en;
	logic [1:0] wr_idx;
	logic wr_ok;

	assign pready = 1'b1;
	assign wr_idx = paddr[4:3];
	assign wr_ok = (paddr[2:0] == 3'd0);
	assign wr_en = psel && penable && pwrite && wr_ok;

	always_comb begin
		prdata = '0;
		if (wr_ok) begin
			unique case (wr_idx)
				wsjq_pkg::RegWorkerCount: prdata = {60'd0, wcount_q};
				wsjq_pkg::RegInlineMargin: prdata = {55'd0, margin_q};
				wsjq_pkg::RegRngSeed: prdata = seed_q;
				default: prdata = '0;
			endcase
		end
	end

	logic accept;
	logic [WW-1:0] in_wid;
	logic [CW-1:0] cnt_w;
	logic [CW:0] cnt_plus;
	logic full_w;
	logic [4:0] rem_sh;
	logic [63:0] ra, rb, rx;
	logic [3:0] wc_eff;
	logic [WW-1:0] rem_wid;
	logic take_ok;

	assign in_ready = (state_q == wsjq_pkg::S_IDLE) && !(ovalid_q && !out_ready);
	assign accept = in_valid && in_ready;
	assign in_wid = WW'(in_data.worker % MAX_WORKERS);
	assign cnt_w = cnt_q[wid_q];
	assign cnt_plus = (CW+1)'(cnt_w) + (CW+1)'(margin_q);
	assign full_w = (cnt_plus >= (CW+1)'(RING_DEPTH)) || (cnt_w >= CW'(RING_DEPTH));
	assign rem_sh = {rem_q, rnd_q[63]};
	assign ra = rs0_q[wid_q];
	assign rb = rs1_q[wid_q];
	assign rx = ra ^ rb;
	assign wc_eff = (wcount_q == 4'd0) ? 4'd1 :
		((32'(wcount_q) > MAX_WORKERS) ? 4'(MAX_WORKERS) : wcount_q);
	assign rem_wid = WW'(rem_q);
	assign take_ok = act_q[rem_wid] && (cnt_q[rem_wid] != '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wsjq_pkg::S_IDLE: if (accept) state_d = wsjq_pkg::S_DECIDE;
			wsjq_pkg::S_DECIDE: begin
				if (!req_q.mode) state_d = wsjq_pkg::S_DONE;
				else if (cnt_w != '0) state_d = wsjq_pkg::S_READ;
				else state_d = wsjq_pkg::S_MOD;
			end
			wsjq_pkg::S_MOD: if (bit_q == 7'd63) state_d = wsjq_pkg::S_CHECK;
			wsjq_pkg::S_CHECK: state_d = take_ok ? wsjq_pkg::S_READ : wsjq_pkg::S_DONE;
			wsjq_pkg::S_READ: state_d = wsjq_pkg::S_DONE;
			wsjq_pkg::S_DONE: state_d = wsjq_pkg::S_IDLE;
			default: state_d = wsjq_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsjq_pkg::S_IDLE;
			wcount_q <= wsjq_pkg::WorkerCountRst;
			margin_q <= wsjq_pkg::InlineMarginRst;
			seed_q <= wsjq_pkg::RngSeedRst;
			for (int w = 0; w < MAX_WORKERS; w++) begin
				head_q[w] <= '0;
				tail_q[w] <= '0;
				cnt_q[w] <= '0;
				rs0_q[w] <= wsjq_pkg::RngSeedRst + 64'(w) * wsjq_pkg::Golden;
				rs1_q[w] <= (wsjq_pkg::RngSeedRst + 64'(w) * wsjq_pkg::Golden)
					^ wsjq_pkg::SeedMix;
			end
			act_q <= '0;
			pend_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			if (wr_en) begin
				unique case (wr_idx)
					wsjq_pkg::RegWorkerCount: wcount_q <= pwdata[3:0];
					wsjq_pkg::RegInlineMargin: margin_q <= pwdata[8:0];
					wsjq_pkg::RegRngSeed: begin
						seed_q <= pwdata;
						for (int w = 0; w < MAX_WORKERS; w++) begin
							rs0_q[w] <= pwdata + 64'(w) * wsjq_pkg::Golden;
							rs1_q[w] <= (pwdata + 64'(w) * wsjq_pkg::Golden)
								^ wsjq_pkg::SeedMix;
						end
					end
					default: ;
				endcase
			end
			unique case (state_q)
				wsjq_pkg::S_IDLE: ;
				wsjq_pkg::S_DECIDE: begin
					act_q[wid_q] <= 1'b1;
					odata_q.victim <= '0;
					odata_q.job_out <= (!req_q.mode && full_w) ? req_q.job : '0;
					tgt_q <= wid_q;
					if (!req_q.mode) begin
						if (full_w) begin
							odata_q.status <= wsjq_pkg::StInline;
						end else begin
							odata_q.status <= wsjq_pkg::StQueued;
							head_q[wid_q] <= PW'(head_q[wid_q] + 1'b1);
							cnt_q[wid_q] <= CW'(cnt_w + 1'b1);
							pend_q <= 13'(pend_q + 1'b1);
						end
					end else if (cnt_w == '0) begin
						odata_q.status <= wsjq_pkg::StNone;
						rnd_q <= ra + rb;
						rs0_q[wid_q] <= {ra[39:0], ra[63:40]} ^ rx ^ {rx[47:0], 16'd0};
						rs1_q[wid_q] <= {rx[26:0], rx[63:27]};
						rem_q <= '0;
						bit_q <= '0;
						wc_q <= wc_eff;
					end
				end
				wsjq_pkg::S_MOD: begin
					rnd_q <= {rnd_q[62:0], 1'b0};
					bit_q <= 7'(bit_q + 1'b1);
					if (rem_sh >= {1'b0, wc_q}) rem_q <= 4'(rem_sh - {1'b0, wc_q});
					else rem_q <= rem_sh[3:0];
				end
				wsjq_pkg::S_CHECK: begin
					odata_q.victim <= 3'(rem_q);
					tgt_q <= rem_wid;
					if (take_ok) odata_q.status <= wsjq_pkg::StStolen;
				end
				wsjq_pkg::S_READ: begin
					if (tgt_q == wid_q) odata_q.status <= wsjq_pkg::StLocal;
					tail_q[tgt_q] <= PW'(tail_q[tgt_q] + 1'b1);
					cnt_q[tgt_q] <= CW'(cnt_q[tgt_q] - 1'b1);
					pend_q <= 13'(pend_q - 1'b1);
				end
				wsjq_pkg::S_DONE: begin
					ovalid_q <= 1'b1;
					odata_q.pending_total <= pend_q;
				end
				default: ;
			endcase
			if (state_q == wsjq_pkg::S_DONE && rd_used_q)
				odata_q.job_out <= rdata_q;
		end
	end

	assign raddr = {tgt_q, tail_q[tgt_q]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_used_q <= 1'b0;
		else if (state_q == wsjq_pkg::S_READ) rd_used_q <= 1'b1;
		else if (state_q == wsjq_pkg::S_DONE) rd_used_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_data;
			wid_q <= in_wid;
		end
		if (state_q == wsjq_pkg::S_DECIDE && !req_q.mode && !full_w)
			ring_q[{wid_q, head_q[wid_q]}] <= req_q.job;
		rdata_q <= ring_q[raddr];
	end

	assign out_valid = ovalid_q;
	assign out_data = odata_q;
endmodule
`default_nettype wire
